@@ hw/rtl/snsc_pkg.sv @@
// ----------------------------------------------------------------------------
// snsc_pkg: shared types and constants for the double hash nonce scanner
// Round constants, initial hash values and the front-to-back queue entry.
// ----------------------------------------------------------------------------
package snsc_pkg;

  localparam int unsigned HdrWords = 19;

  localparam logic CmdLoadWord  = 1'b0;
  localparam logic CmdHashNonce = 1'b1;

  typedef struct packed {
    logic        last_nonce;
    logic [31:0] nonce;
  } job_t;

  localparam logic [31:0] HINIT [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] KROUND [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  function automatic logic [31:0] bswap(input logic [31:0] x);
    bswap = {x[7:0], x[15:8], x[23:16], x[31:24]};
  endfunction

endpackage

@@ hw/rtl/snsc_front.sv @@
// ----------------------------------------------------------------------------
// snsc_front: input decode and header store
// Writes header words, pushes nonce jobs into a small queue for the hasher.
// ----------------------------------------------------------------------------
module snsc_front #(
  parameter int unsigned QueueDepth = 2
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                command,
  input  logic [4:0]          word_index,
  input  logic [31:0]         header_word,
  input  logic [31:0]         nonce,
  input  logic                last_nonce,
  input  logic                engine_idle,
  output logic [31:0]         header [snsc_pkg::HdrWords],
  output logic                job_valid,
  input  logic                job_ready,
  output snsc_pkg::job_t      job
);

  localparam int unsigned PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;

  snsc_pkg::job_t  q [QueueDepth];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [PtrW:0]   count;
  logic            push;
  logic            pop;
  logic            load;

  // nonces need a free queue slot; hold loads until every queued nonce is hashed
  assign in_ready  = (command == snsc_pkg::CmdHashNonce) ?
                     (count != (PtrW+1)'(QueueDepth)) : ((count == '0) && engine_idle);
  assign push      = in_valid && in_ready && (command == snsc_pkg::CmdHashNonce);
  assign load      = in_valid && in_ready && (command == snsc_pkg::CmdLoadWord);
  assign job_valid = (count != '0);
  assign pop       = job_valid && job_ready;
  assign job       = q[rd_ptr];

  always_ff @(posedge clk) begin
    if (load && (word_index < 5'(snsc_pkg::HdrWords))) begin
      header[word_index] <= header_word;
    end
    if (push) begin
      q[wr_ptr] <= '{last_nonce: last_nonce, nonce: nonce};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PtrW'(QueueDepth - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PtrW'(QueueDepth - 1)) ? '0 : rd_ptr + 1'b1;
      end
      count <= count + (PtrW+1)'(push) - (PtrW+1)'(pop);
    end
  end

`ifndef NO_ASSERTIONS
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push && !pop |-> count != (PtrW+1)'(QueueDepth)) else $error("queue overflow");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> count != '0) else $error("queue underflow");
  a_count_step: assert property (@(posedge clk) disable iff (rst)
    push && !pop |=> count == $past(count) + 1'b1) else $error("count step");
`endif

endmodule

@@ hw/rtl/snsc_back.sv @@
// ----------------------------------------------------------------------------
// snsc_back: iterative double hash engine and result tracking
// One shared round unit runs three compressions per nonce, then scores it.
// ----------------------------------------------------------------------------
module snsc_back (
  input  logic                clk,
  input  logic                rst,
  input  logic [31:0]         header [snsc_pkg::HdrWords],
  input  logic                job_valid,
  output logic                job_ready,
  input  snsc_pkg::job_t      job,
  input  logic [255:0]        share_limit,
  input  logic [255:0]        block_limit,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [31:0]         lead_nonce,
  output logic [8:0]          lead_zeros,
  output logic [63:0]         hash_part,
  output logic [1:0]          part_index,
  output logic [31:0]         share_count,
  output logic [31:0]         block_count,
  output logic [31:0]         first_hit_nonce,
  output logic                last_of_run
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_ROUND = 3'd1;
  localparam logic [2:0] S_FOLD  = 3'd2;
  localparam logic [2:0] S_SCORE = 3'd3;
  localparam logic [2:0] S_ZERO  = 3'd4;
  localparam logic [2:0] S_UPD   = 3'd5;
  localparam logic [2:0] S_EMIT  = 3'd6;

  logic [2:0]   state;
  logic [1:0]   pass;
  logic [5:0]   rnd;
  logic [31:0]  w [16];
  logic [31:0]  a, b, c, d, e, f, g, h;
  logic [31:0]  st [8];
  logic         last;
  logic [31:0]  cur_nonce;
  logic [255:0] hv;
  logic [8:0]   zeros;
  logic         le_share;
  logic         le_block;
  logic [2:0]   zword;
  logic [1:0]   emit_k;

  logic [31:0]  kept_nonce;
  logic [8:0]   kept_zeros;
  logic [255:0] kept_hash;
  logic [31:0]  share_tally;
  logic [31:0]  block_tally;
  logic [31:0]  kept_first;

  logic [31:0] s0, s1, ch, maj, t1, t2, wn, ws0, ws1;
  logic [31:0] blk [16];
  logic [255:0] dig;

  assign s0  = {a[1:0], a[31:2]} ^ {a[12:0], a[31:13]} ^ {a[21:0], a[31:22]};
  assign s1  = {e[5:0], e[31:6]} ^ {e[10:0], e[31:11]} ^ {e[24:0], e[31:25]};
  assign ch  = (e & f) ^ (~e & g);
  assign maj = (a & b) ^ (a & c) ^ (b & c);
  assign t1  = h + s1 + ch + snsc_pkg::KROUND[rnd] + w[0];
  assign t2  = s0 + maj;
  assign ws0 = {w[1][6:0], w[1][31:7]} ^ {w[1][17:0], w[1][31:18]} ^ (w[1] >> 3);
  assign ws1 = {w[14][16:0], w[14][31:17]} ^ {w[14][18:0], w[14][31:19]} ^ (w[14] >> 10);
  assign wn  = w[0] + ws0 + w[9] + ws1;

  // message block for the next pass, picked by the pass that just finished
  always_comb begin
    for (int i = 0; i < 16; i++) begin
      blk[i] = '0;
    end
    case (pass)
      2'd0: begin
        blk[0]  = snsc_pkg::bswap(header[16]);
        blk[1]  = snsc_pkg::bswap(header[17]);
        blk[2]  = snsc_pkg::bswap(header[18]);
        blk[3]  = snsc_pkg::bswap(cur_nonce);
        blk[4]  = 32'h80000000;
        blk[15] = 32'd640;
      end
      2'd1: begin
        // first digest straight from the fold sums
        blk[0]  = st[0] + a;
        blk[1]  = st[1] + b;
        blk[2]  = st[2] + c;
        blk[3]  = st[3] + d;
        blk[4]  = st[4] + e;
        blk[5]  = st[5] + f;
        blk[6]  = st[6] + g;
        blk[7]  = st[7] + h;
        blk[8]  = 32'h80000000;
        blk[15] = 32'd256;
      end
      default: begin
        blk[0] = '0;
      end
    endcase
  end

  // digest as a little-endian 256-bit number: byte 31 most significant
  always_comb begin
    for (int i = 0; i < 8; i++) begin
      dig[255 - 32*i -: 32] = snsc_pkg::bswap(st[7 - i]);
    end
  end

  assign job_ready = (state == S_IDLE);
  assign out_valid = (state == S_EMIT);
  assign lead_nonce = kept_nonce;
  assign lead_zeros = kept_zeros;
  assign hash_part = kept_hash[255 - 64*emit_k -: 64];
  assign part_index = emit_k;
  assign share_count = share_tally;
  assign block_count = block_tally;
  assign first_hit_nonce = kept_first;
  assign last_of_run = (emit_k == 2'd3);

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      pass        <= '0;
      rnd         <= '0;
      emit_k      <= '0;
      kept_nonce  <= '0;
      kept_zeros  <= '0;
      kept_hash   <= '0;
      share_tally <= '0;
      block_tally <= '0;
      kept_first  <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (job_valid) begin
            cur_nonce <= job.nonce;
            last      <= job.last_nonce;
            pass      <= 2'd0;
            rnd       <= '0;
            for (int i = 0; i < 8; i++) begin
              st[i] <= snsc_pkg::HINIT[i];
            end
            {a, b, c, d, e, f, g, h} <= {snsc_pkg::HINIT[0], snsc_pkg::HINIT[1],
              snsc_pkg::HINIT[2], snsc_pkg::HINIT[3], snsc_pkg::HINIT[4],
              snsc_pkg::HINIT[5], snsc_pkg::HINIT[6], snsc_pkg::HINIT[7]};
            for (int i = 0; i < 16; i++) begin
              w[i] <= snsc_pkg::bswap(header[i]);
            end
            state <= S_ROUND;
          end
        end
        S_ROUND: begin
          h <= g; g <= f; f <= e; e <= d + t1;
          d <= c; c <= b; b <= a; a <= t1 + t2;
          for (int i = 0; i < 15; i++) begin
            w[i] <= w[i+1];
          end
          w[15] <= wn;
          rnd <= rnd + 1'b1;
          if (rnd == 6'd63) begin
            state <= S_FOLD;
          end
        end
        S_FOLD: begin
          // add vars to state (pass 1: reset); next block unless pass 2
          if (pass == 2'd2) begin
            st[0] <= st[0] + a; st[1] <= st[1] + b; st[2] <= st[2] + c;
            st[3] <= st[3] + d; st[4] <= st[4] + e; st[5] <= st[5] + f;
            st[6] <= st[6] + g; st[7] <= st[7] + h;
            state <= S_SCORE;
          end else if (pass == 2'd1) begin
            for (int i = 0; i < 8; i++) begin
              st[i] <= snsc_pkg::HINIT[i];
            end
            {a, b, c, d, e, f, g, h} <= {snsc_pkg::HINIT[0], snsc_pkg::HINIT[1],
              snsc_pkg::HINIT[2], snsc_pkg::HINIT[3], snsc_pkg::HINIT[4],
              snsc_pkg::HINIT[5], snsc_pkg::HINIT[6], snsc_pkg::HINIT[7]};
            pass <= 2'd2;
            state <= S_ROUND;
          end else begin
            st[0] <= st[0] + a; st[1] <= st[1] + b; st[2] <= st[2] + c;
            st[3] <= st[3] + d; st[4] <= st[4] + e; st[5] <= st[5] + f;
            st[6] <= st[6] + g; st[7] <= st[7] + h;
            {a, b, c, d, e, f, g, h} <= {st[0] + a, st[1] + b, st[2] + c,
              st[3] + d, st[4] + e, st[5] + f, st[6] + g, st[7] + h};
            pass <= 2'd1;
            state <= S_ROUND;
          end
          if (pass != 2'd2) begin
            for (int i = 0; i < 16; i++) begin
              w[i] <= blk[i];
            end
          end
        end
        S_SCORE: begin
          hv       <= dig;
          le_share <= (dig <= share_limit);
          le_block <= (dig <= block_limit);
          zeros    <= '0;
          zword    <= '0;
          state    <= S_ZERO;
        end
        S_ZERO: begin
          // count leading zeros one 32-bit word per cycle
          if (hv[255 - 32*zword -: 32] == '0) begin
            zeros <= zeros + 9'd32;
            zword <= zword + 1'b1;
            if (zword == 3'd7) begin
              state <= S_UPD;
            end
          end else begin
            for (int i = 0; i < 32; i++) begin
              if (hv[255 - 32*zword -: 32] >> i == 32'd1) begin
                zeros <= zeros + 9'(31 - i);
              end
            end
            state <= S_UPD;
          end
        end
        S_UPD: begin
          if (zeros > kept_zeros) begin
            kept_zeros <= zeros;
            kept_nonce <= cur_nonce;
            kept_hash  <= hv;
          end
          if (le_share) begin
            share_tally <= share_tally + 1'b1;
            // tally about to become one
            if (share_tally == 32'd0) begin
              kept_first <= cur_nonce;
            end
            if (le_block) begin
              block_tally <= block_tally + 1'b1;
            end
          end
          emit_k <= '0;
          state  <= last ? S_EMIT : S_IDLE;
        end
        S_EMIT: begin
          if (out_ready) begin
            emit_k <= emit_k + 1'b1;
            if (emit_k == 2'd3) begin
              kept_nonce  <= '0;
              kept_zeros  <= '0;
              kept_hash   <= '0;
              share_tally <= '0;
              block_tally <= '0;
              kept_first  <= '0;
              state       <= S_IDLE;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    job_valid && job_ready |=> state == S_ROUND) else $error("job not started");
  a_clear_after: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && last_of_run |=> share_tally == '0 && kept_zeros == '0)
    else $error("accumulators not cleared");
  a_pass_range: assert property (@(posedge clk) disable iff (rst)
    state == S_ROUND |-> pass != 2'd3) else $error("bad pass");
`endif

endmodule

@@ hw/rtl/sha256d_nonce_scan_core.sv @@
// ----------------------------------------------------------------------------
// sha256d_nonce_scan_core: double hash nonce scanner
// Header load, nonce hashing, best/share/block tracking and batch report.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_ready): command 1 queues one nonce; up to two
// nonces wait in the queue while the engine works, so the sender stalls only
// when it is full. Command 0 writes one header word, but only once the
// queue is empty and the engine is idle, so every nonce hashes the header
// that was loaded before it.
// Each nonce takes three 64-round compressions on one shared round unit
// (two over the 80-byte header, one over the first digest): the engine takes
// the job, runs the rounds and folds, scores the digest, counts leading zeros
// and updates the tallies before it takes the next nonce from the queue. A
// nonce marked last then gives four report items on out_valid/out_ready,
// part_index 0 to 3, one per cycle while out_ready is high; a stalled
// receiver holds the engine in the report until all four are taken. Targets
// are to be written by the user on the cfg port only while idle; the block
// itself does not enforce this. Reset clears tallies, best hash and queue;
// targets return to all ones; header words stay undefined until written.
// ----------------------------------------------------------------------------
module sha256d_nonce_scan_core #(
  parameter int unsigned QueueDepth = 2
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        command,
  input  logic [4:0]  word_index,
  input  logic [31:0] header_word,
  input  logic [31:0] nonce,
  input  logic        last_nonce,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] lead_nonce,
  output logic [8:0]  lead_zeros,
  output logic [63:0] hash_part,
  output logic [1:0]  part_index,
  output logic [31:0] share_count,
  output logic [31:0] block_count,
  output logic [31:0] first_hit_nonce,
  output logic        last_of_run
);

  logic [255:0]   share_limit;
  logic [255:0]   block_limit;
  logic [31:0]    header [snsc_pkg::HdrWords];
  logic           job_valid;
  logic           job_ready;
  snsc_pkg::job_t job;

  always_ff @(posedge clk) begin
    if (rst) begin
      share_limit <= '1;
      block_limit <= '1;
    end else if (cfg_we) begin
      if (cfg_index[2]) begin
        block_limit[255 - 64*cfg_index[1:0] -: 64] <= cfg_data;
      end else begin
        share_limit[255 - 64*cfg_index[1:0] -: 64] <= cfg_data;
      end
    end
  end

  snsc_front #(.QueueDepth(QueueDepth)) u_front (
    .clk, .rst, .in_valid, .in_ready, .command, .word_index, .header_word,
    .nonce, .last_nonce, .engine_idle(job_ready), .header, .job_valid,
    .job_ready, .job
  );

  snsc_back u_back (
    .clk, .rst, .header, .job_valid, .job_ready, .job, .share_limit,
    .block_limit, .out_valid, .out_ready, .lead_nonce, .lead_zeros, .hash_part,
    .part_index, .share_count, .block_count, .first_hit_nonce, .last_of_run
  );

endmodule

@@ dv/sha256d_scan_tb_pkg.sv @@
// ----------------------------------------------------------------------------
// sha256d_scan_tb_pkg: codes shared by the nonce scanner testbench
// Input command codes and target register indexes.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
package sha256d_scan_tb_pkg;

  localparam logic CmdLoadWord  = 1'b0;
  localparam logic CmdHashNonce = 1'b1;

  localparam logic [2:0] ShareTargetW0 = 3'd0;
  localparam logic [2:0] BlockTargetW0 = 3'd4;

  localparam int unsigned HeaderWords = 19;

endpackage

@@ dv/sha256d_scan_monitor.sv @@
// ----------------------------------------------------------------------------
// sha256d_scan_monitor: scoreboard for the double hash nonce scanner
// Tracks header, targets and accumulators from the channels, predicts each
// batch report and compares every report item field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
module sha256d_scan_monitor (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic        command,
  input  logic [4:0]  word_index,
  input  logic [31:0] header_word,
  input  logic [31:0] nonce,
  input  logic        last_nonce,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [31:0] lead_nonce,
  input  logic [8:0]  lead_zeros,
  input  logic [63:0] hash_part,
  input  logic [1:0]  part_index,
  input  logic [31:0] share_count,
  input  logic [31:0] block_count,
  input  logic [31:0] first_hit_nonce,
  input  logic        last_of_run,
  output int          reports_due,
  output int          fail_count
);

  typedef struct {
    logic [31:0] lead_nonce;
    logic [8:0]  lead_zeros;
    logic [63:0] hash_part;
    logic [1:0]  part_index;
    logic [31:0] share_count;
    logic [31:0] block_count;
    logic [31:0] first_hit_nonce;
    logic        last_of_run;
  } report_t;

  report_t     expected_reports[$];
  logic [31:0] hdr_words [sha256d_scan_tb_pkg::HeaderWords];
  logic [255:0] share_limit, block_limit;
  logic [255:0] top_hash;
  logic [31:0] top_nonce, share_tally, block_tally, first_share;
  logic [8:0]  top_zeros;

  function automatic logic [31:0] ror(logic [31:0] x, int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  function automatic logic [31:0] swap32(logic [31:0] x);
    return {x[7:0], x[15:8], x[23:16], x[31:24]};
  endfunction

  function automatic logic [255:0] init_state();
    logic [255:0] s;
    for (int i = 0; i < 8; i++) s[255 - 32*i -: 32] = snsc_pkg::HINIT[i];
    return s;
  endfunction

  function automatic logic [255:0] compress64(logic [255:0] st, logic [511:0] blk);
    logic [31:0] w [64];
    logic [31:0] a, b, c, d, e, f, g, h, t1, t2, s0, s1;
    for (int i = 0; i < 16; i++) w[i] = blk[511 - 32*i -: 32];
    for (int i = 16; i < 64; i++) begin
      s0 = ror(w[i-15], 7) ^ ror(w[i-15], 18) ^ (w[i-15] >> 3);
      s1 = ror(w[i-2], 17) ^ ror(w[i-2], 19) ^ (w[i-2] >> 10);
      w[i] = w[i-16] + s0 + w[i-7] + s1;
    end
    {a, b, c, d, e, f, g, h} = st;
    for (int i = 0; i < 64; i++) begin
      t1 = h + (ror(e, 6) ^ ror(e, 11) ^ ror(e, 25)) + ((e & f) ^ (~e & g)) +
           snsc_pkg::KROUND[i] + w[i];
      t2 = (ror(a, 2) ^ ror(a, 13) ^ ror(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
      h = g; g = f; f = e; e = d + t1;
      d = c; c = b; b = a; a = t1 + t2;
    end
    return {st[255:224] + a, st[223:192] + b, st[191:160] + c, st[159:128] + d,
            st[127:96] + e, st[95:64] + f, st[63:32] + g, st[31:0] + h};
  endfunction

  // Double hash of header plus nonce, read back as a little-endian number.
  function automatic logic [255:0] scan_value(logic [31:0] n);
    logic [511:0] blk;
    logic [255:0] s, v;
    for (int i = 0; i < 16; i++) blk[511 - 32*i -: 32] = swap32(hdr_words[i]);
    s = compress64(init_state(), blk);
    blk = '0;
    blk[511:480] = swap32(hdr_words[16]);
    blk[479:448] = swap32(hdr_words[17]);
    blk[447:416] = swap32(hdr_words[18]);
    blk[415:384] = swap32(n);
    blk[383:352] = 32'h8000_0000;
    blk[31:0]    = 32'd640;
    s = compress64(s, blk);
    s = compress64(init_state(), {s, 32'h8000_0000, 192'd0, 32'd256});
    for (int j = 0; j < 32; j++) v[8*j +: 8] = s[255 - 8*j -: 8];
    return v;
  endfunction

  task automatic clear_tallies();
    top_hash = '0;
    top_nonce = '0;
    top_zeros = '0;
    share_tally = '0;
    block_tally = '0;
    first_share = '0;
  endtask

  task automatic score_nonce(logic [31:0] n, logic last);
    logic [255:0] v;
    int zc;
    report_t r;
    v = scan_value(n);
    zc = 0;
    while (zc < 256 && !v[255 - zc]) zc++;
    if (zc > top_zeros) begin
      top_zeros = 9'(zc);
      top_nonce = n;
      top_hash = v;
    end
    if (v <= share_limit) begin
      share_tally++;
      if (share_tally == 32'd1) first_share = n;
      if (v <= block_limit) block_tally++;
    end
    if (last) begin
      for (int k = 0; k < 4; k++) begin
        r.lead_nonce = top_nonce;
        r.lead_zeros = top_zeros;
        r.hash_part = top_hash[255 - 64*k -: 64];
        r.part_index = 2'(k);
        r.share_count = share_tally;
        r.block_count = block_tally;
        r.first_hit_nonce = first_share;
        r.last_of_run = (k == 3);
        expected_reports.push_back(r);
      end
      clear_tallies();
    end
  endtask

  task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    report_t r;
    if (rst) begin
      expected_reports.delete();
      share_limit = '1;
      block_limit = '1;
      fail_count = 0;
      clear_tallies();
    end else begin
      if (cfg_we) begin
        if (cfg_index < sha256d_scan_tb_pkg::BlockTargetW0)
          share_limit[255 - 64*(cfg_index - sha256d_scan_tb_pkg::ShareTargetW0) -: 64] =
            cfg_data;
        else
          block_limit[255 - 64*(cfg_index - sha256d_scan_tb_pkg::BlockTargetW0) -: 64] =
            cfg_data;
      end
      if (in_valid && in_ready) begin
        if (command == sha256d_scan_tb_pkg::CmdLoadWord) begin
          // drop loads past the last header word
          if (word_index < sha256d_scan_tb_pkg::HeaderWords)
            hdr_words[word_index] = header_word;
        end else begin
          score_nonce(nonce, last_nonce);
        end
      end
      if (out_valid && out_ready) begin
        if (expected_reports.size() == 0) begin
          $error("report item with nothing expected");
          fail_count++;
        end else begin
          r = expected_reports.pop_front();
          check_field("lead_nonce", r.lead_nonce, lead_nonce);
          check_field("lead_zeros", r.lead_zeros, lead_zeros);
          check_field("hash_part", r.hash_part, hash_part);
          check_field("part_index", r.part_index, part_index);
          check_field("share_count", r.share_count, share_count);
          check_field("block_count", r.block_count, block_count);
          check_field("first_hit_nonce", r.first_hit_nonce, first_hit_nonce);
          check_field("last_of_run", r.last_of_run, last_of_run);
        end
      end
    end
    reports_due = expected_reports.size();
  end

endmodule

@@ dv/sha256d_nonce_scan_core_test.sv @@
// ----------------------------------------------------------------------------
// sha256d_nonce_scan_core_test: testbench top for the nonce scanner
// Drives header loads, nonce batches and target settings with random
// stalls on both channels; the monitor predicts and checks every report.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
module sha256d_nonce_scan_core_test;

  localparam int unsigned CycleLimit = 2_000_000;
  localparam int unsigned SettleCycles = 700;
  localparam int unsigned ItemGoal = 360;

  logic        clk, rst;
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [63:0] cfg_data;
  logic        in_valid, in_ready;
  logic        command;
  logic [4:0]  word_index;
  logic [31:0] header_word, nonce;
  logic        last_nonce;
  logic        out_valid, out_ready;
  logic [31:0] lead_nonce, share_count, block_count, first_hit_nonce;
  logic [8:0]  lead_zeros;
  logic [63:0] hash_part;
  logic [1:0]  part_index;
  logic        last_of_run;
  int          reports_due, fail_count;

  bit          calm;
  int unsigned items_sent;
  int unsigned cycles = 0;
  int unsigned stall_left = 0;

  sha256d_nonce_scan_core dut (.*);
  sha256d_scan_monitor monitor (.*);

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("sha256d_nonce_scan_core verification failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      stall_left <= 0;
      out_ready <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_ready <= 1'b0;
    end else if (!calm && $urandom_range(0, 4) == 0) begin
      stall_left <= $urandom_range(0, 12);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  task automatic send_item(logic cmd, logic [4:0] idx, logic [31:0] word,
                           logic [31:0] n, logic last);
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    in_valid <= 1'b1;
    command <= cmd;
    word_index <= idx;
    header_word <= word;
    nonce <= n;
    last_nonce <= last;
    @(negedge clk);
    while (!in_ready) @(negedge clk);
    @(posedge clk);
    items_sent++;
  endtask

  task automatic load_header();
    for (int i = 0; i < sha256d_scan_tb_pkg::HeaderWords; i++)
      send_item(sha256d_scan_tb_pkg::CmdLoadWord, 5'(i), $urandom, $urandom,
                1'($urandom_range(0, 1)));
  endtask

  // Loads past the header end, which the block must ignore.
  task automatic send_stray_load();
    send_item(sha256d_scan_tb_pkg::CmdLoadWord,
              5'($urandom_range(sha256d_scan_tb_pkg::HeaderWords, 31)), $urandom, $urandom,
              1'($urandom_range(0, 1)));
  endtask

  task automatic send_batch(int unsigned count);
    for (int unsigned i = 0; i < count; i++) begin
      if ($urandom_range(0, 7) == 0) send_stray_load();
      send_item(sha256d_scan_tb_pkg::CmdHashNonce, 5'($urandom), $urandom, $urandom,
                i == count - 1);
    end
  endtask

  task automatic write_targets(logic [255:0] share, logic [255:0] blk);
    in_valid <= 1'b0;
    for (int i = 0; i < 4; i++) begin
      cfg_we <= 1'b1;
      cfg_index <= sha256d_scan_tb_pkg::ShareTargetW0 + 3'(i);
      cfg_data <= share[255 - 64*i -: 64];
      @(posedge clk);
      cfg_we <= 1'b1;
      cfg_index <= sha256d_scan_tb_pkg::BlockTargetW0 + 3'(i);
      cfg_data <= blk[255 - 64*i -: 64];
      @(posedge clk);
    end
    cfg_we <= 1'b0;
  endtask

  // Wait for every report, then for nonces that report nothing to finish.
  task automatic drain();
    in_valid <= 1'b0;
    @(negedge clk);
    while (reports_due != 0) @(negedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  function automatic logic [255:0] random_target(int unsigned shift);
    logic [255:0] t;
    for (int i = 0; i < 8; i++) t[32*i +: 32] = $urandom;
    return t >> shift;
  endfunction

  initial begin
    int unsigned phase;
    rst = 1'b1;
    calm = 1'b0;
    items_sent = 0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_valid = 1'b0;
    command = sha256d_scan_tb_pkg::CmdLoadWord;
    word_index = '0;
    header_word = '0;
    nonce = '0;
    last_nonce = 1'b0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: every share counts, no block ever
    write_targets('1, '0);
    send_item(sha256d_scan_tb_pkg::CmdLoadWord, 5'd0, 32'h0000_0000, '0, 1'b0);
    send_item(sha256d_scan_tb_pkg::CmdLoadWord, 5'd1, 32'hffff_ffff, '1, 1'b1);
    for (int i = 2; i < sha256d_scan_tb_pkg::HeaderWords; i++)
      send_item(sha256d_scan_tb_pkg::CmdLoadWord, 5'(i), $urandom, '0, 1'b0);
    send_item(sha256d_scan_tb_pkg::CmdLoadWord, 5'd19, $urandom, '0, 1'b0);
    send_item(sha256d_scan_tb_pkg::CmdLoadWord, 5'd31, '1, '1, 1'b1);
    send_item(sha256d_scan_tb_pkg::CmdHashNonce, 5'd31, '1, 32'h0000_0000, 1'b0);
    send_item(sha256d_scan_tb_pkg::CmdHashNonce, 5'd0, '0, 32'hffff_ffff, 1'b1);

    phase = 0;
    while (items_sent < ItemGoal) begin
      drain();
      case (phase % 4)
        0: write_targets('0, '1);
        1: write_targets('1, '1);
        default: write_targets(random_target($urandom_range(0, 2)),
                               random_target($urandom_range(1, 4)));
      endcase
      if (phase % 2 == 1) load_header();
      if (items_sent > ItemGoal * 85 / 100) calm = 1'b1;
      repeat ($urandom_range(2, 5)) send_batch($urandom_range(1, 6));
      phase++;
    end

    in_valid <= 1'b0;
    @(negedge clk);
    while (reports_due != 0) @(negedge clk);
    repeat (SettleCycles) @(posedge clk);
    if (fail_count == 0)
      $display("sha256d_nonce_scan_core verification clean");
    else
      $display("sha256d_nonce_scan_core verification failed");
    $finish;
  end

endmodule

@@ files.f @@
hw/rtl/snsc_pkg.sv
hw/rtl/snsc_front.sv
hw/rtl/snsc_back.sv
hw/rtl/sha256d_nonce_scan_core.sv
dv/sha256d_scan_tb_pkg.sv
dv/sha256d_scan_monitor.sv
dv/sha256d_nonce_scan_core_test.sv
